// ----- rtl/dpdd_pkg.sv -----
package dpdd_pkg;

    // sample field widths
    localparam int ENC_W       = 24;
    localparam int GAIN_W      = 16;
    localparam int DRV_W       = 8;
    localparam int DRIVE_LIM   = 100;

    // encoder averaging
    localparam int WHEEL_COUNT = 6;
    localparam int ENC_FIELDS  = 6;
    localparam int AVG_N       = (WHEEL_COUNT > ENC_FIELDS) ? ENC_FIELDS :
                                 ((WHEEL_COUNT < 1) ? 1 : WHEEL_COUNT);
    localparam int TOT_W       = ENC_W + 3;
    localparam int MAG_W       = TOT_W - 1;
    localparam int RCP_S       = MAG_W + 2;
    localparam int RCP_W       = RCP_S + 1;
    localparam logic [RCP_W-1:0] RCP_M = RCP_W'((64'd1 << RCP_S) / AVG_N);

    // pid datapath
    localparam int ERR_W       = ENC_W + 1;
    localparam int DE_W        = ERR_W + 1;
    localparam int SUM_W       = 40;
    localparam int SUM_LO_W    = SUM_W / 2;
    localparam int SUM_HI_W    = SUM_W - SUM_LO_W;
    localparam int ACC_W       = 57;
    localparam int MOVE_SHIFT  = 12;
    localparam int TURN_SHIFT  = 18;
    localparam int MIX_W       = ACC_W - MOVE_SHIFT + 1;

    // configuration register indexes
    localparam int CFG_IDX_W   = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_MOVE_KP = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MOVE_KI = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MOVE_KD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_KP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_KI = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_KD = 3'd5;

    localparam logic signed [GAIN_W-1:0] MOVE_KP_RST = 16'sd819;
    localparam logic signed [GAIN_W-1:0] TURN_KP_RST = 16'sd1229;

    // pipeline stage numbers
    localparam int ST_IN   = 0;
    localparam int ST_SUM  = 1;
    localparam int ST_RCP  = 2;
    localparam int ST_AVG  = 3;
    localparam int ST_ERR  = 4;
    localparam int ST_MUL  = 5;
    localparam int ST_ACC  = 6;
    localparam int ST_POW  = 7;
    localparam int ST_OUT  = 8;
    localparam int STAGES  = 9;

    typedef struct packed {
        logic err;
        logic mul;
        logic acc;
        logic pow;
    } t_pid_ld;

endpackage

// ----- rtl/dpdd_pid.sv -----
module dpdd_pid #(
    parameter int SHIFT = dpdd_pkg::MOVE_SHIFT
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  dpdd_pkg::t_pid_ld                        i_ld,
    input  logic signed [dpdd_pkg::GAIN_W-1:0]       i_kp,
    input  logic signed [dpdd_pkg::GAIN_W-1:0]       i_ki,
    input  logic signed [dpdd_pkg::GAIN_W-1:0]       i_kd,
    input  logic signed [dpdd_pkg::ERR_W-1:0]        i_err,
    output logic signed [dpdd_pkg::ACC_W-SHIFT-1:0]  o_pow
);
    import dpdd_pkg::*;

    localparam int KP_W = GAIN_W + ERR_W;
    localparam int KD_W = GAIN_W + DE_W;
    localparam int KL_W = GAIN_W + SUM_LO_W + 1;
    localparam int KH_W = GAIN_W + SUM_HI_W;
    localparam int POW_W = ACC_W - SHIFT;
    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic [ACC_W-1:0] BIAS = ACC_W'((64'd1 << SHIFT) - 64'd1);

    // loop state, also the payload of the error stage
    logic signed [ERR_W-1:0]  r_last;
    logic signed [SUM_W-1:0]  r_sum;
    logic signed [DE_W-1:0]   r_de;

    logic signed [KP_W-1:0]   r_p_kp;
    logic signed [KD_W-1:0]   r_p_kd;
    logic signed [KL_W-1:0]   r_p_lo;
    logic signed [KH_W-1:0]   r_p_hi;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [POW_W-1:0]  r_pow;

    logic signed [SUM_W:0]    n_sum_w;
    logic signed [SUM_W-1:0]  n_sum;
    logic signed [DE_W-1:0]   n_de;
    logic signed [ACC_W-1:0]  n_acc;
    logic signed [ACC_W-1:0]  n_biased;

    // saturating error sum and error change
    always_comb begin
        n_sum_w = (SUM_W+1)'(r_sum) + (SUM_W+1)'(i_err);
        if (n_sum_w[SUM_W] != n_sum_w[SUM_W-1]) begin
            n_sum = n_sum_w[SUM_W] ? SUM_MIN : SUM_MAX;
        end else begin
            n_sum = n_sum_w[SUM_W-1:0];
        end
        n_de = DE_W'(i_err) - DE_W'(r_last);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= '0;
            r_sum  <= '0;
        end else if (i_ld.err) begin
            r_last <= i_err;
            r_sum  <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld.err) begin
            r_de <= n_de;
        end
    end

    // sum gain split in two narrow products
    always_ff @(posedge i_clk) begin
        if (i_ld.mul) begin
            r_p_kp <= KP_W'(i_kp) * KP_W'(r_last);
            r_p_kd <= KD_W'(i_kd) * KD_W'(r_de);
            r_p_lo <= KL_W'(i_ki) * KL_W'($signed({1'b0, r_sum[SUM_LO_W-1:0]}));
            r_p_hi <= KH_W'(i_ki) * KH_W'($signed(r_sum[SUM_W-1:SUM_LO_W]));
        end
    end

    always_comb begin
        n_acc = ACC_W'(r_p_kp) + ACC_W'(r_p_kd) + ACC_W'(r_p_lo)
              + (ACC_W'(r_p_hi) <<< SUM_LO_W);
        // round toward zero before the arithmetic shift
        n_biased = r_acc + (r_acc[ACC_W-1] ? $signed(BIAS) : '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_ld.acc) begin
            r_acc <= n_acc;
        end
        if (i_ld.pow) begin
            r_pow <= n_biased[ACC_W-1:SHIFT];
        end
    end

    assign o_pow = r_pow;

endmodule

// ----- rtl/dual_pid_differential_drive_core.sv -----
// channel   | handshake                  | payload
// ----------+----------------------------+---------------------------------------------
// sample in | i_valid / o_ready          | i_enc_* (6), i_heading, i_target_distance,
//           |                            | i_target_heading, 24 bit signed each
// drive out | o_valid / i_ready          | o_left_drive, o_right_drive, 8 bit signed
// config    | i_cfg_we, no wait          | i_cfg_idx, i_cfg_data (16 bit gain)
//
// nine register stages from the input register to the drive register. one request per
// cycle flows through while the drive side does not stall; the rate is set by the loop
// state update, which takes in one new error for each request in both loops.
// reset clears the stage valid bits, the error sums and last errors, and loads the
// default gains. a stall on the drive side holds only the stages that are full;
// empty stages keep taking requests until the pipeline fills.
module dual_pid_differential_drive_core (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    output logic                                    o_ready,
    input  logic signed [dpdd_pkg::ENC_W-1:0]       i_enc_left_front,
    input  logic signed [dpdd_pkg::ENC_W-1:0]       i_enc_left_mid,
    input  logic signed [dpdd_pkg::ENC_W-1:0]       i_enc_left_back,
    input  logic signed [dpdd_pkg::ENC_W-1:0]       i_enc_right_front,
    input  logic signed [dpdd_pkg::ENC_W-1:0]       i_enc_right_mid,
    input  logic signed [dpdd_pkg::ENC_W-1:0]       i_enc_right_back,
    input  logic signed [dpdd_pkg::ENC_W-1:0]       i_heading,
    input  logic signed [dpdd_pkg::ENC_W-1:0]       i_target_distance,
    input  logic signed [dpdd_pkg::ENC_W-1:0]       i_target_heading,
    output logic                                    o_valid,
    input  logic                                    i_ready,
    output logic signed [dpdd_pkg::DRV_W-1:0]       o_left_drive,
    output logic signed [dpdd_pkg::DRV_W-1:0]       o_right_drive,
    input  logic                                    i_cfg_we,
    input  logic [dpdd_pkg::CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [dpdd_pkg::GAIN_W-1:0]             i_cfg_data
);
    import dpdd_pkg::*;

    localparam int MPOW_W = ACC_W - MOVE_SHIFT;
    localparam int TPOW_W = ACC_W - TURN_SHIFT;
    localparam logic signed [MIX_W-1:0] MIX_HI = MIX_W'(DRIVE_LIM);
    localparam logic signed [MIX_W-1:0] MIX_LO = -MIX_HI;

    // saturate a mixed power to the drive range
    function automatic logic signed [DRV_W-1:0] clamp_drive(
        input logic signed [MIX_W-1:0] v
    );
        if (v > MIX_HI) begin
            return DRV_W'(MIX_HI);
        end else if (v < MIX_LO) begin
            return DRV_W'(MIX_LO);
        end
        return DRV_W'(v);
    endfunction

    // ---------------------------------------------------------------- gains
    logic signed [GAIN_W-1:0] r_move_kp, r_move_ki, r_move_kd;
    logic signed [GAIN_W-1:0] r_turn_kp, r_turn_ki, r_turn_kd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_move_kp <= MOVE_KP_RST;
            r_move_ki <= '0;
            r_move_kd <= '0;
            r_turn_kp <= TURN_KP_RST;
            r_turn_ki <= '0;
            r_turn_kd <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MOVE_KP: r_move_kp <= $signed(i_cfg_data);
                CFG_MOVE_KI: r_move_ki <= $signed(i_cfg_data);
                CFG_MOVE_KD: r_move_kd <= $signed(i_cfg_data);
                CFG_TURN_KP: r_turn_kp <= $signed(i_cfg_data);
                CFG_TURN_KI: r_turn_ki <= $signed(i_cfg_data);
                CFG_TURN_KD: r_turn_kd <= $signed(i_cfg_data);
                default: ;  // indexes past the list are dropped
            endcase
        end
    end

    // ---------------------------------------------------------------- flow control
    // each stage moves when it is empty or the stage after it moves
    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] n_vld;
    logic [STAGES-1:0] w_rdy;
    logic [STAGES-1:0] w_ld;

    always_comb begin
        w_rdy[STAGES-1] = !r_vld[STAGES-1] || i_ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
        w_ld[0] = i_valid && w_rdy[0];
        for (int k = 1; k < STAGES; k++) begin
            w_ld[k] = r_vld[k-1] && w_rdy[k];
        end
        n_vld = r_vld;
        if (w_rdy[0]) begin
            n_vld[0] = i_valid;
        end
        for (int k = 1; k < STAGES; k++) begin
            if (w_rdy[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_ready = w_rdy[ST_IN];
    assign o_valid = r_vld[ST_OUT];

    // ---------------------------------------------------------------- input register
    logic signed [ENC_W-1:0] r_a_enc [ENC_FIELDS];
    logic signed [ENC_W-1:0] r_a_head;
    logic signed [ENC_W-1:0] r_a_tdist;
    logic signed [ENC_W-1:0] r_a_thead;

    always_ff @(posedge i_clk) begin
        if (w_ld[ST_IN]) begin
            r_a_enc[0] <= i_enc_left_front;
            r_a_enc[1] <= i_enc_left_mid;
            r_a_enc[2] <= i_enc_left_back;
            r_a_enc[3] <= i_enc_right_front;
            r_a_enc[4] <= i_enc_right_mid;
            r_a_enc[5] <= i_enc_right_back;
            r_a_head   <= i_heading;
            r_a_tdist  <= i_target_distance;
            r_a_thead  <= i_target_heading;
        end
    end

    // ---------------------------------------------------------------- encoder total
    // only the first AVG_N wheels take part in the average
    logic signed [TOT_W-1:0] n_total;
    logic signed [TOT_W-1:0] r_b_total;
    logic signed [ENC_W-1:0] r_b_tdist;
    logic signed [ERR_W-1:0] r_b_terr;

    always_comb begin
        n_total = '0;
        for (int i = 0; i < AVG_N; i++) begin
            n_total = n_total + TOT_W'(r_a_enc[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld[ST_SUM]) begin
            r_b_total <= n_total;
            r_b_tdist <= r_a_tdist;
            r_b_terr  <= ERR_W'(r_a_thead) - ERR_W'(r_a_head);
        end
    end

    // ---------------------------------------------------------------- reciprocal estimate
    // magnitude times floor(2^RCP_S / n) gives the quotient or one below it
    logic [MAG_W-1:0]       n_mag;
    logic [MAG_W+RCP_W-1:0] w_rcp_prod;
    logic [MAG_W-1:0]       r_c_mag;
    logic                   r_c_neg;
    logic [MAG_W-1:0]       r_c_qest;
    logic signed [ENC_W-1:0] r_c_tdist;
    logic signed [ERR_W-1:0] r_c_terr;

    always_comb begin
        n_mag      = r_b_total[TOT_W-1] ? MAG_W'(-r_b_total) : MAG_W'(r_b_total);
        w_rcp_prod = (MAG_W+RCP_W)'(n_mag) * (MAG_W+RCP_W)'(RCP_M);
    end

    always_ff @(posedge i_clk) begin
        if (w_ld[ST_RCP]) begin
            r_c_mag   <= n_mag;
            r_c_neg   <= r_b_total[TOT_W-1];
            r_c_qest  <= w_rcp_prod[RCP_S +: MAG_W];
            r_c_tdist <= r_b_tdist;
            r_c_terr  <= r_b_terr;
        end
    end

    // ---------------------------------------------------------------- quotient correction
    logic [MAG_W+2:0]        w_qn;
    logic [MAG_W+2:0]        w_rem;
    logic [MAG_W-1:0]        w_quo;
    logic [ENC_W-1:0]        r_d_avg;
    logic                    r_d_neg;
    logic signed [ENC_W-1:0] r_d_tdist;
    logic signed [ERR_W-1:0] r_d_terr;

    always_comb begin
        w_qn  = (MAG_W+3)'(r_c_qest) * (MAG_W+3)'(AVG_N);
        w_rem = (MAG_W+3)'(r_c_mag) - w_qn;
        w_quo = (w_rem >= (MAG_W+3)'(AVG_N)) ? r_c_qest + MAG_W'(1) : r_c_qest;
    end

    always_ff @(posedge i_clk) begin
        if (w_ld[ST_AVG]) begin
            r_d_avg   <= w_quo[ENC_W-1:0];
            r_d_neg   <= r_c_neg;
            r_d_tdist <= r_c_tdist;
            r_d_terr  <= r_c_terr;
        end
    end

    // ---------------------------------------------------------------- distance error
    // average keeps its sign apart, so the error is one add or subtract
    logic signed [ERR_W-1:0] w_move_err;

    always_comb begin
        if (r_d_neg) begin
            w_move_err = ERR_W'(r_d_tdist) + $signed({1'b0, r_d_avg});
        end else begin
            w_move_err = ERR_W'(r_d_tdist) - $signed({1'b0, r_d_avg});
        end
    end

    // ---------------------------------------------------------------- the two loops
    t_pid_ld                  w_pid_ld;
    logic signed [MPOW_W-1:0] w_move_pow;
    logic signed [TPOW_W-1:0] w_turn_pow;

    assign w_pid_ld = '{err: w_ld[ST_ERR], mul: w_ld[ST_MUL],
                        acc: w_ld[ST_ACC], pow: w_ld[ST_POW]};

    dpdd_pid #(
        .SHIFT (MOVE_SHIFT)
    ) u_move_pid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ld    (w_pid_ld),
        .i_kp    (r_move_kp),
        .i_ki    (r_move_ki),
        .i_kd    (r_move_kd),
        .i_err   (w_move_err),
        .o_pow   (w_move_pow)
    );

    // heading error carries 1/64 degree, hence the larger shift
    dpdd_pid #(
        .SHIFT (TURN_SHIFT)
    ) u_turn_pid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ld    (w_pid_ld),
        .i_kp    (r_turn_kp),
        .i_ki    (r_turn_ki),
        .i_kd    (r_turn_kd),
        .i_err   (r_d_terr),
        .o_pow   (w_turn_pow)
    );

    // ---------------------------------------------------------------- mixing and clamp
    logic signed [MIX_W-1:0] w_left_mix;
    logic signed [MIX_W-1:0] w_right_mix;
    logic signed [DRV_W-1:0] r_left;
    logic signed [DRV_W-1:0] r_right;

    always_comb begin
        w_left_mix  = MIX_W'(w_move_pow) + MIX_W'(w_turn_pow);
        w_right_mix = MIX_W'(w_move_pow) - MIX_W'(w_turn_pow);
    end

    always_ff @(posedge i_clk) begin
        if (w_ld[ST_OUT]) begin
            r_left  <= clamp_drive(w_left_mix);
            r_right <= clamp_drive(w_right_mix);
        end
    end

    assign o_left_drive  = r_left;
    assign o_right_drive = r_right;

endmodule

// ----- rtl/dpdd_checker.sv -----
module dpdd_checker (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    input  logic                                    o_ready,
    input  logic                                    o_valid,
    input  logic                                    i_ready,
    input  logic signed [dpdd_pkg::DRV_W-1:0]       o_left_drive,
    input  logic signed [dpdd_pkg::DRV_W-1:0]       o_right_drive
);
    import dpdd_pkg::*;

    localparam logic signed [DRV_W-1:0] LIM_HI = DRV_W'(DRIVE_LIM);
    localparam logic signed [DRV_W-1:0] LIM_LO = -LIM_HI;

    // drives never leave the clamp range
    a_drive_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_left_drive <= LIM_HI) && (o_left_drive >= LIM_LO)
                 && (o_right_drive <= LIM_HI) && (o_right_drive >= LIM_LO))
        else $error("drive outside clamp range");

    // an empty output stage means the whole pipe can move
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled while output empty");

    // reset empties the pipe
    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result pending after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_left_drive)
                               && $stable(o_right_drive))
        else $error("stalled result changed");

endmodule

bind dual_pid_differential_drive_core dpdd_checker u_dpdd_checker (.*);
